### src/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg - shared types and codes of the fair slot allocator
// Command classification, result codes and back-end sequencer states.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	// Fixed field widths of the stream items.
	localparam int IN_ID_W = 8;
	localparam int SLOT_W  = 2;
	localparam int KIND_W  = 3;
	localparam int CFG_W   = 3;
	localparam int TDATA_W = 16;

	localparam logic [CFG_W-1:0] ACTIVE_SLOTS_RESET = 3'd4;

	typedef enum logic {
		FUNC_ACQUIRE = 1'b0,
		FUNC_RELEASE = 1'b1
	} func_t;

	typedef enum logic [KIND_W-1:0] {
		EV_GRANTED     = 3'd0,
		EV_QUEUED      = 3'd1,
		EV_RELEASED    = 3'd2,
		EV_REJECTED    = 3'd3,
		EV_BAD_RELEASE = 3'd4
	} event_kind_t;

	// Classification that the front end attaches to each command.
	typedef struct packed {
		func_t             func;
		logic              zero_id;
		logic              slot_oob;
		logic [SLOT_W-1:0] slot;
	} cmd_ctl_t;

	typedef enum logic {
		BK_EXEC  = 1'b0,
		BK_GRANT = 1'b1
	} back_state_t;

endpackage

### src/ffsa_front.sv
// ----------------------------------------------------------------------------
// ffsa_front - input side of the fair slot allocator
// Accepts request transactions and classifies them into commands.
// ----------------------------------------------------------------------------
module ffsa_front #(
	parameter int NUM_SLOTS = 4,
	parameter int ID_BITS   = 8
) (
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// s_tdata: requester_id [7:0], slot_index [9:8], zero fill above
	input  logic [ffsa_pkg::TDATA_W-1:0]  s_tdata,
	// s_tuser: func [0]
	input  logic                          s_tuser,
	input  logic                          fifo_full,
	output logic                          push,
	output ffsa_pkg::cmd_ctl_t            push_ctl,
	output logic [ID_BITS-1:0]            push_id
);

	logic [ffsa_pkg::IN_ID_W-1:0] raw_id;
	logic [ffsa_pkg::SLOT_W-1:0]  raw_slot;

	assign raw_id   = s_tdata[ffsa_pkg::IN_ID_W-1:0];
	assign raw_slot = s_tdata[ffsa_pkg::IN_ID_W +: ffsa_pkg::SLOT_W];

	assign s_tready = !fifo_full;
	assign push     = s_tvalid && !fifo_full;

	// Ids are kept at ID_BITS; narrower ids drop the upper input bits.
	assign push_id = ID_BITS'(raw_id);

	always_comb begin
		push_ctl.func     = ffsa_pkg::func_t'(s_tuser);
		push_ctl.zero_id  = (push_id == '0);
		push_ctl.slot_oob = (int'(raw_slot) >= NUM_SLOTS);
		push_ctl.slot     = raw_slot;
	end

endmodule

### src/ffsa_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ffsa_cmd_fifo - two-entry command queue
// Decouples the classifying front end from the executing back end.
// ----------------------------------------------------------------------------
module ffsa_cmd_fifo #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output logic [DATA_W-1:0] pop_data
);

	logic [DATA_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

### src/ffsa_back.sv
// ----------------------------------------------------------------------------
// ffsa_back - execution side of the fair slot allocator
// Holds slot ownership and the wait queue, and drives the result register.
// ----------------------------------------------------------------------------
module ffsa_back #(
	parameter int NUM_SLOTS   = 4,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ffsa_pkg::CFG_W-1:0]    active_slots,
	input  logic                          cmd_valid,
	input  ffsa_pkg::cmd_ctl_t            cmd_ctl,
	input  logic [ID_BITS-1:0]            cmd_id,
	output logic                          cmd_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ffsa_pkg::TDATA_W-1:0]  m_tdata,
	output logic [ffsa_pkg::KIND_W-1:0]   m_tuser,
	output logic                          m_tlast
);

	localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int PAD_W  = ffsa_pkg::TDATA_W - ffsa_pkg::IN_ID_W - ffsa_pkg::SLOT_W;

	// Slot ownership: busy bits are reset, owner ids are written on grant.
	logic [NUM_SLOTS-1:0] busy_q;
	logic [ID_BITS-1:0]   owner_q [NUM_SLOTS];

	// Wait queue memory with a registered head read.
	logic [ID_BITS-1:0]   wq_mem [QUEUE_DEPTH];
	logic [ID_BITS-1:0]   head_rd_q;
	logic [PTR_W-1:0]     head_q;
	logic [PTR_W-1:0]     tail_q;
	logic [CNT_W-1:0]     count_q;

	ffsa_pkg::back_state_t state_q;
	ffsa_pkg::back_state_t state_d;

	logic [NUM_SLOTS-1:0] grant_mask;
	logic [NUM_SLOTS-1:0] free_vec;
	logic [NUM_SLOTS-1:0] rel_mask;
	logic [SIDX_W-1:0]    lf_idx;
	logic                 any_free;
	logic [SIDX_W-1:0]    rel_idx;
	logic                 out_free;
	logic                 grant_follows;

	// Actions decided for this cycle.
	logic                  emit;
	ffsa_pkg::event_kind_t emit_kind;
	logic [ID_BITS-1:0]    emit_id;
	logic [ffsa_pkg::SLOT_W-1:0] emit_slot;
	logic                  emit_last;
	logic                  do_take;
	logic [ID_BITS-1:0]    take_id;
	logic                  do_free;
	logic                  do_push;
	logic                  do_head_pop;

	ffsa_pkg::event_kind_t kind_q;
	logic [ID_BITS-1:0]    out_id_q;
	logic [ffsa_pkg::SLOT_W-1:0] out_slot_q;
	logic                  last_q;
	logic                  valid_q;

	assign out_free = !valid_q || m_tready;
	assign rel_idx  = SIDX_W'(cmd_ctl.slot);

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++)
			grant_mask[i] = (int'(active_slots) > i);
		free_vec = ~busy_q & grant_mask;
		any_free = |free_vec;
		lf_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--)
			if (free_vec[i])
				lf_idx = SIDX_W'(i);
		rel_mask = '0;
		if (!cmd_ctl.slot_oob)
			rel_mask[rel_idx] = 1'b1;
		grant_follows = (count_q != '0) && (|(free_vec | (rel_mask & grant_mask)));
	end

	// Sequencer outputs.
	always_comb begin
		emit        = 1'b0;
		emit_kind   = ffsa_pkg::EV_GRANTED;
		emit_id     = '0;
		emit_slot   = '0;
		emit_last   = 1'b1;
		do_take     = 1'b0;
		take_id     = cmd_id;
		do_free     = 1'b0;
		do_push     = 1'b0;
		do_head_pop = 1'b0;
		cmd_pop     = 1'b0;
		unique case (state_q)
			ffsa_pkg::BK_EXEC: begin
				if (cmd_valid && out_free) begin
					emit    = 1'b1;
					cmd_pop = 1'b1;
					if (cmd_ctl.func == ffsa_pkg::FUNC_ACQUIRE) begin
						if (cmd_ctl.zero_id) begin
							emit_kind = ffsa_pkg::EV_REJECTED;
						end else if (count_q == '0 && any_free) begin
							emit_kind = ffsa_pkg::EV_GRANTED;
							emit_id   = cmd_id;
							emit_slot = ffsa_pkg::SLOT_W'(lf_idx);
							do_take   = 1'b1;
						end else if (count_q == CNT_W'(QUEUE_DEPTH)) begin
							emit_kind = ffsa_pkg::EV_REJECTED;
							emit_id   = cmd_id;
						end else begin
							emit_kind = ffsa_pkg::EV_QUEUED;
							emit_id   = cmd_id;
							do_push   = 1'b1;
						end
					end else begin
						emit_slot = cmd_ctl.slot;
						if (cmd_ctl.slot_oob || !busy_q[rel_idx]) begin
							emit_kind = ffsa_pkg::EV_BAD_RELEASE;
						end else begin
							emit_kind = ffsa_pkg::EV_RELEASED;
							emit_id   = owner_q[rel_idx];
							emit_last = !grant_follows;
							do_free   = 1'b1;
						end
					end
				end
			end
			ffsa_pkg::BK_GRANT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_kind   = ffsa_pkg::EV_GRANTED;
					emit_id     = head_rd_q;
					emit_slot   = ffsa_pkg::SLOT_W'(lf_idx);
					do_take     = 1'b1;
					take_id     = head_rd_q;
					do_head_pop = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffsa_pkg::BK_EXEC:
				if (do_free && grant_follows)
					state_d = ffsa_pkg::BK_GRANT;
			ffsa_pkg::BK_GRANT:
				if (out_free)
					state_d = ffsa_pkg::BK_EXEC;
			default: state_d = ffsa_pkg::BK_EXEC;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffsa_pkg::BK_EXEC;
			busy_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_take)
				busy_q[lf_idx] <= 1'b1;
			if (do_free)
				busy_q[rel_idx] <= 1'b0;
			if (do_push) begin
				tail_q  <= (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (do_head_pop) begin
				head_q  <= (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
			if (emit)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_take)
			owner_q[lf_idx] <= take_id;
		if (do_push)
			wq_mem[tail_q] <= cmd_id;
		head_rd_q <= wq_mem[head_q];
		if (emit) begin
			kind_q     <= emit_kind;
			out_id_q   <= emit_id;
			out_slot_q <= emit_slot;
			last_q     <= emit_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_slot_q, ffsa_pkg::IN_ID_W'(out_id_q)};

endmodule

### src/fifo_fair_slot_allocator.sv
// ----------------------------------------------------------------------------
// fifo_fair_slot_allocator - FIFO-ordered slot allocator
// Grants a pool of slots to requesters strictly in order of arrival.
// ----------------------------------------------------------------------------
// An acquire transaction (tuser 0) is granted the lowest free slot below
// active_slots when nobody is waiting; otherwise the id joins a wait queue of
// QUEUE_DEPTH entries, or is rejected when that queue is full or the id is
// zero. A release transaction (tuser 1) frees its slot and reports the owner;
// when someone waits and a grantable slot is free, a grant to the queue head
// follows as a second result, and only that second result carries tlast.
// Releasing a free or nonexistent slot yields a single bad-release result.
// Timing: the back end executes one command per cycle unless its output stalls
// or a grant is pending; a release that hands its slot on moves the sequencer
// to BK_GRANT, which emits the grant as a second result as the result register
// holds one result at a time; the queue head already waits in a register read
// from the wait-queue memory. A two-entry command queue sits between the input
// and the back end, so up to two request transactions are accepted while a
// result waits to be taken. active_slots is written through the cfg channel,
// which is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module fifo_fair_slot_allocator #(
	parameter int NUM_SLOTS   = 4,
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration: active_slots write data
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ffsa_pkg::CFG_W-1:0]    cfg_data,
	// Request stream
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// s_axis_tdata: requester_id [7:0], slot_index [9:8], zero fill [15:10]
	input  logic [ffsa_pkg::TDATA_W-1:0]  s_axis_tdata,
	// s_axis_tuser: func [0]
	input  logic                          s_axis_tuser,
	// Result stream
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// m_axis_tdata: owner_id [7:0], granted_slot [9:8], zero fill [15:10]
	output logic [ffsa_pkg::TDATA_W-1:0]  m_axis_tdata,
	// m_axis_tuser: event_kind [2:0]
	output logic [ffsa_pkg::KIND_W-1:0]   m_axis_tuser,
	output logic                          m_axis_tlast
);

	localparam int CTL_W = $bits(ffsa_pkg::cmd_ctl_t);
	localparam int CMD_W = CTL_W + ID_BITS;

	logic [ffsa_pkg::CFG_W-1:0] active_slots_q;

	logic               push;
	ffsa_pkg::cmd_ctl_t push_ctl;
	logic [ID_BITS-1:0] push_id;
	logic               fifo_full;
	logic               cmd_pop;
	logic               cmd_valid;
	logic [CMD_W-1:0]   cmd_data;
	ffsa_pkg::cmd_ctl_t cmd_ctl;
	logic [ID_BITS-1:0] cmd_id;

	// The configuration register accepts a write in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_slots_q <= ffsa_pkg::ACTIVE_SLOTS_RESET;
		end else if (cfg_valid) begin
			active_slots_q <= cfg_data;
		end
	end

	ffsa_front #(
		.NUM_SLOTS (NUM_SLOTS),
		.ID_BITS   (ID_BITS)
	) u_front (
		.s_tvalid  (s_axis_tvalid),
		.s_tready  (s_axis_tready),
		.s_tdata   (s_axis_tdata),
		.s_tuser   (s_axis_tuser),
		.fifo_full (fifo_full),
		.push      (push),
		.push_ctl  (push_ctl),
		.push_id   (push_id)
	);

	ffsa_cmd_fifo #(
		.DATA_W (CMD_W)
	) u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_id, push_ctl}),
		.full      (fifo_full),
		.pop       (cmd_pop),
		.pop_valid (cmd_valid),
		.pop_data  (cmd_data)
	);

	assign cmd_ctl = ffsa_pkg::cmd_ctl_t'(cmd_data[CTL_W-1:0]);
	assign cmd_id  = cmd_data[CTL_W +: ID_BITS];

	ffsa_back #(
		.NUM_SLOTS   (NUM_SLOTS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.active_slots (active_slots_q),
		.cmd_valid    (cmd_valid),
		.cmd_ctl      (cmd_ctl),
		.cmd_id       (cmd_id),
		.cmd_pop      (cmd_pop),
		.m_tvalid     (m_axis_tvalid),
		.m_tready     (m_axis_tready),
		.m_tdata      (m_axis_tdata),
		.m_tuser      (m_axis_tuser),
		.m_tlast      (m_axis_tlast)
	);

endmodule
